// File: design/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg
// Shared types, constants and header decode for the copying collector.
// ----------------------------------------------------------------------------
package cgc_pkg;

  localparam int DefHeapWords = 8192;
  localparam int BankShift    = 15;
  localparam int MaxBankBytes = 1 << BankShift;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_START = 3'd2,
    OP_FWD   = 3'd3,
    OP_SCAN  = 3'd4
  } op_t;

  localparam logic [2:0] TAG_NUMBER = 3'd0;
  localparam logic [2:0] TAG_IMM    = 3'd1;
  localparam logic [2:0] TAG_PAIR   = 3'd2;
  localparam logic [2:0] TAG_STRING = 3'd3;
  localparam logic [2:0] TAG_SYMBOL = 3'd4;
  localparam logic [2:0] TAG_VECTOR = 3'd5;
  localparam logic [2:0] TAG_PROC   = 3'd6;
  localparam logic [2:0] TAG_FLOAT  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_F_CHECK,
    ST_F_HDR,
    ST_F_COPY,
    ST_F_MARK,
    ST_S_TOP,
    ST_S_HDR,
    ST_S_FLOOP,
    ST_S_FRD,
    ST_S_FWB,
    ST_S_ADV,
    ST_DONE
  } state_t;

  // object size in words, rounded up to even
  function automatic logic [29:0] size_words(input logic [31:0] h);
    logic [2:0]  t;
    logic [29:0] len;
    logic [29:0] n;
    t   = h[3:1];
    len = {2'b00, h[31:4]};
    if (t == TAG_NUMBER || t == TAG_IMM || t == TAG_STRING) begin
      n = 30'd1 + ((len + 30'd3) >> 2);
    end else if (t == TAG_PROC) begin
      n = 30'd2 + len;
    end else begin
      n = 30'd1 + len;
    end
    return (n + 30'd1) & ~30'd1;
  endfunction

endpackage

// File: design/cgc_in_if.sv
// ----------------------------------------------------------------------------
// cgc_in_if
// Command channel: opcode, word index and data word.
// ----------------------------------------------------------------------------
interface cgc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [12:0] word_index;
  logic [31:0] data_word;

  modport source (output valid, output opcode, output word_index, output data_word,
                  input ready);
  modport sink (input valid, input opcode, input word_index, input data_word,
                output ready);
endinterface

// File: design/cgc_out_if.sv
// ----------------------------------------------------------------------------
// cgc_out_if
// Result channel: result value and scan error flag.
// ----------------------------------------------------------------------------
interface cgc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        scan_error;

  modport source (output valid, output result_value, output scan_error, input ready);
  modport sink (input valid, input result_value, input scan_error, output ready);
endinterface

// File: design/copying_garbage_collector.sv
// ----------------------------------------------------------------------------
// copying_garbage_collector
// Two-bank heap with a Cheney copying collector driven by host commands.
// ----------------------------------------------------------------------------
// Forward root returns a non-pointer or null value unchanged, the new address of an
// already forwarded object, or the old pointer of an object that does not fit; else it
// copies the object word by word and marks the old header with the new address.
// Scan and flip forwards the fields of pointer objects, then flips the banks.
// One transaction in flight.
// Reset clears bank select, free and scan offsets; heap contents stay undefined.
module copying_garbage_collector #(
  parameter int HEAP_WORDS = cgc_pkg::DefHeapWords
) (
  input  logic   clk,
  input  logic   rst,
  cgc_in_if.sink    in_ch,
  cgc_out_if.source out_ch
);
  import cgc_pkg::*;

  // HEAP_WORDS must be a power of two, which the block does not check; addresses wrap by truncation
  localparam int AW       = $clog2(HEAP_WORDS);
  localparam int CapBytes = (HEAP_WORDS * 4 < MaxBankBytes) ? HEAP_WORDS * 4 : MaxBankBytes;
  localparam int CapWords = CapBytes / 4;
  localparam int FW       = AW + 2;

  state_t       state, state_next;
  logic         cur, cur_next;
  logic [15:0]  free_off, free_off_next;
  logic [15:0]  scan_off, scan_off_next;
  logic [31:0]  ptr, ptr_next;
  logic [31:0]  res, res_next;
  logic         err, err_next;
  logic         in_scan, in_scan_next;
  logic [AW:0]  k, k_next;
  logic [AW:0]  nwords, nwords_next;
  logic [FW-1:0] fwc, fwc_next;
  logic [27:0]  rem, rem_next;
  logic [31:0]  step, step_next;
  logic         ov;
  logic [31:0]  o_val;
  logic         o_err;

  logic          rd_en, wr_en;
  logic [AW:0]   rd_addr, wr_addr;
  logic [31:0]   rd_data, wr_data;

  cgc_heap #(.AW(AW)) u_heap (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  logic [16:0]   idx_ext, sw_ext, dw_ext, w_ext;
  logic [AW-1:0] idx, sw, dw, w;
  logic [2:0]    ptag, htag;
  logic [29:0]   hsize;
  logic [32:0]  fit_sum;
  logic [31:0]  np;
  logic [29:0]  flds;
  logic [32:0]  adv_sum;
  logic [31:0]  fret;
  logic         fdone;
  logic         out_free;

  assign idx_ext  = {4'b0, in_ch.word_index};
  assign idx      = idx_ext[AW-1:0];
  assign sw_ext   = {4'b0, ptr[14:3], 1'b0};
  assign sw       = sw_ext[AW-1:0];
  assign dw_ext   = {3'b0, free_off[15:2]};
  assign dw       = dw_ext[AW-1:0];
  assign w_ext    = {3'b0, scan_off[15:2]};
  assign w        = w_ext[AW-1:0];
  assign ptag     = ptr[2:0];
  assign htag     = rd_data[3:1];
  assign hsize    = size_words(rd_data);
  assign fit_sum  = {17'b0, free_off} + {1'b0, hsize, 2'b00};
  assign np       = {16'b0, free_off} | ({31'b0, ~cur} << BankShift);
  assign flds     = ((htag == TAG_PROC) ? 30'd3 : 30'd2) + {2'b00, rd_data[31:4]};
  assign adv_sum  = {17'b0, scan_off} + {1'b0, step};
  assign out_free = !ov || out_ch.ready;

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = ov;
  assign out_ch.result_value = o_val;
  assign out_ch.scan_error   = o_err;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    free_off_next = free_off;
    scan_off_next = scan_off;
    ptr_next      = ptr;
    res_next      = res;
    err_next      = err;
    in_scan_next  = in_scan;
    k_next        = k;
    nwords_next   = nwords;
    fwc_next      = fwc;
    rem_next      = rem;
    step_next     = step;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    fret          = ptr;
    fdone         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_next = '0;
          err_next = 1'b0;
          case (in_ch.opcode)
            OP_WRITE: begin
              wr_en      = 1'b1;
              wr_addr    = {cur, idx};
              wr_data    = in_ch.data_word;
              state_next = ST_DONE;
            end
            OP_READ: begin
              rd_en      = 1'b1;
              rd_addr    = {cur, idx};
              state_next = ST_READ;
            end
            OP_START: begin
              free_off_next = '0;
              scan_off_next = '0;
              state_next    = ST_DONE;
            end
            OP_FWD: begin
              ptr_next     = in_ch.data_word;
              in_scan_next = 1'b0;
              state_next   = ST_F_CHECK;
            end
            OP_SCAN: begin
              state_next = ST_S_TOP;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_next   = rd_data;
        state_next = ST_DONE;
      end
      ST_F_CHECK: begin
        if (ptag == TAG_NUMBER || ptag == TAG_IMM || ptag == TAG_FLOAT ||
            ptr[31:3] == '0) begin
          fret  = ptr;
          fdone = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = {ptr[BankShift], sw};
          state_next = ST_F_HDR;
        end
      end
      ST_F_HDR: begin
        if (rd_data[0]) begin
          fret  = {rd_data[31:3], ptag};
          fdone = 1'b1;
        end else if (fit_sum > 33'(CapBytes)) begin
          fret  = ptr;
          fdone = 1'b1;
        end else begin
          nwords_next = hsize[AW:0];
          k_next      = '0;
          state_next  = ST_F_COPY;
        end
      end
      ST_F_COPY: begin
        // read word k while writing word k-1 from the previous read
        if (k != nwords) begin
          rd_en   = 1'b1;
          rd_addr = {ptr[BankShift], sw + k[AW-1:0]};
        end
        if (k != '0) begin
          wr_en   = 1'b1;
          wr_addr = {~cur, dw + k[AW-1:0] - AW'(1)};
          wr_data = rd_data;
        end
        if (k == nwords) begin
          state_next = ST_F_MARK;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_F_MARK: begin
        wr_en         = 1'b1;
        wr_addr       = {ptr[BankShift], sw};
        wr_data       = np | 32'h1;
        free_off_next = free_off + 16'({nwords, 2'b00});
        fret          = np | {29'b0, ptag};
        fdone         = 1'b1;
      end
      ST_S_TOP: begin
        if (scan_off < free_off) begin
          rd_en      = 1'b1;
          rd_addr    = {~cur, w};
          state_next = ST_S_HDR;
        end else begin
          cur_next   = ~cur;
          res_next   = {16'b0, free_off};
          state_next = ST_DONE;
        end
      end
      ST_S_HDR: begin
        if (htag == TAG_FLOAT) begin
          err_next   = 1'b1;
          cur_next   = ~cur;
          res_next   = {16'b0, free_off};
          state_next = ST_DONE;
        end else if (htag == TAG_PAIR || htag == TAG_SYMBOL || htag == TAG_VECTOR ||
                     htag == TAG_PROC) begin
          fwc_next   = FW'(w) + ((htag == TAG_PROC) ? FW'(2) : FW'(1));
          rem_next   = rd_data[31:4];
          step_next  = {flds[29:1], 1'b0, 2'b00};
          state_next = ST_S_FLOOP;
        end else begin
          step_next  = {hsize, 2'b00};
          state_next = ST_S_ADV;
        end
      end
      ST_S_FLOOP: begin
        if (rem == '0 || fwc >= FW'(CapWords)) begin
          state_next = ST_S_ADV;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = {~cur, fwc[AW-1:0]};
          state_next = ST_S_FRD;
        end
      end
      ST_S_FRD: begin
        ptr_next     = rd_data;
        in_scan_next = 1'b1;
        state_next   = ST_F_CHECK;
      end
      ST_S_FWB: begin
        wr_en      = 1'b1;
        wr_addr    = {~cur, fwc[AW-1:0]};
        wr_data    = res;
        fwc_next   = fwc + 1'b1;
        rem_next   = rem - 1'b1;
        state_next = ST_S_FLOOP;
      end
      ST_S_ADV: begin
        if (adv_sum >= 33'(CapBytes)) begin
          scan_off_next = 16'(CapBytes);
        end else begin
          scan_off_next = adv_sum[15:0];
        end
        state_next = ST_S_TOP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // return from the forward routine
    if (fdone) begin
      res_next   = fret;
      state_next = in_scan ? ST_S_FWB : ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= 1'b0;
      free_off <= '0;
      scan_off <= '0;
      in_scan  <= 1'b0;
      ov       <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      free_off <= free_off_next;
      scan_off <= scan_off_next;
      in_scan  <= in_scan_next;
      if (state == ST_DONE && out_free) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    res    <= res_next;
    err    <= err_next;
    k      <= k_next;
    nwords <= nwords_next;
    fwc    <= fwc_next;
    rem    <= rem_next;
    step   <= step_next;
    if (state == ST_DONE && out_free) begin
      o_val <= res;
      o_err <= err;
    end
  end
endmodule

// File: design/cgc_heap.sv
// ----------------------------------------------------------------------------
// cgc_heap
// Both heap banks in one synchronous RAM; address MSB selects the bank.
// ----------------------------------------------------------------------------
module cgc_heap #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW:0]   rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW:0]   wr_addr,
  input  logic [31:0]   wr_data
);
  localparam int Depth = 2 << AW;

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-address collision (overlapping copy)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end
endmodule
